/* rtl/core/lsd_pkg.sv */
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared constants and types for the LZSS stream decoder: token layout,
// window geometry and the command word passed from the parser to the copier.
// ----------------------------------------------------------------------------
package lsd_pkg;

   localparam int WINDOW_BITS    = 11;
   localparam int LEN_BITS       = 4;
   localparam int MIN_EXTRA      = 1;
   localparam int LOOKAHEAD      = 17;

   localparam int WIN_SIZE       = 1 << WINDOW_BITS;
   localparam int LIT_TOKEN_BITS = 9;
   localparam int REF_TOKEN_BITS = 1 + WINDOW_BITS + LEN_BITS;
   localparam int MAX_TOKEN_BITS = (LIT_TOKEN_BITS > REF_TOKEN_BITS) ?
                                   LIT_TOKEN_BITS : REF_TOKEN_BITS;
   localparam int CNT_W          = $clog2(MAX_TOKEN_BITS + 1);
   // token shift register, flag bit kept separately
   localparam int TOK_W          = (WINDOW_BITS + LEN_BITS > 8) ?
                                   (WINDOW_BITS + LEN_BITS) : 8;

   localparam int OUT_LIMIT      = 17;
   localparam int EMIT_W         = $clog2(OUT_LIMIT + 1);
   localparam int RUN_MAX        = (1 << LEN_BITS) - 1 + MIN_EXTRA;
   localparam int RUN_W          = (RUN_MAX > 1) ? $clog2(RUN_MAX + 1) : 1;
   localparam int FILL_W         = WINDOW_BITS + 1;

   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [WINDOW_BITS-1:0] INIT_WP =
      WINDOW_BITS'(WIN_SIZE - (LOOKAHEAD % WIN_SIZE));

   typedef struct packed {
      logic                   is_lit;
      logic [7:0]             lit;
      logic [WINDOW_BITS-1:0] pos;
      logic [LEN_BITS-1:0]    len;
   } cmd_type;

endpackage

/* rtl/core/lsd_parser.sv */
// ----------------------------------------------------------------------------
// lsd_parser
// Front end: shifts each compressed byte into the token register, most
// significant bit first, and issues a command when a token completes.
// ----------------------------------------------------------------------------
module lsd_parser
   import lsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       push_valid,
   input  logic       push_ready,
   output cmd_type    push_cmd
);

   logic [TOK_W-1:0] tok_ff, tok_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             flag_ff, flag_in;
   logic             done;
   logic             accept;

   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;

   always_comb begin
      tok_in   = tok_ff;
      cnt_in   = cnt_ff;
      flag_in  = flag_ff;
      done     = 1'b0;
      push_cmd = '0;
      for (int b = 7; b >= 0; b--) begin
         // first bit of a token is its flag
         if (cnt_in == '0) begin
            flag_in = req_in_byte[b];
         end
         tok_in = {tok_in[TOK_W-2:0], req_in_byte[b]};
         cnt_in = cnt_in + 1'b1;
         if (flag_in && cnt_in == CNT_W'(LIT_TOKEN_BITS)) begin
            done            = 1'b1;
            push_cmd.is_lit = 1'b1;
            push_cmd.lit    = tok_in[7:0];
            tok_in          = '0;
            cnt_in          = '0;
         end else if (!flag_in && cnt_in == CNT_W'(REF_TOKEN_BITS)) begin
            done            = 1'b1;
            push_cmd.is_lit = 1'b0;
            push_cmd.pos    = tok_in[WINDOW_BITS+LEN_BITS-1:LEN_BITS];
            push_cmd.len    = tok_in[LEN_BITS-1:0];
            tok_in          = '0;
            cnt_in          = '0;
         end
      end
   end

   assign push_valid = accept && done;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff  <= '0;
         cnt_ff  <= '0;
         flag_ff <= 1'b0;
      end else if (accept) begin
         tok_ff  <= tok_in;
         cnt_ff  <= cnt_in;
         flag_ff <= flag_in;
      end
   end

endmodule

/* rtl/core/lsd_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// lsd_cmd_fifo
// Short command queue between the token parser and the window copier.
// ----------------------------------------------------------------------------
module lsd_cmd_fifo
   import lsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/core/lsd_copier.sv */
// ----------------------------------------------------------------------------
// lsd_copier
// Back end: owns the history window, emits literals and copies matches one
// byte at a time (read cycle, then write-and-emit cycle), drives the result
// register.
// ----------------------------------------------------------------------------
module lsd_copier
   import lsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   output logic       cmd_ready,
   input  cmd_type    cmd,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_READ  = 3'b010,
      ST_WRITE = 3'b100
   } copy_state_type;

   logic [7:0]             window [WIN_SIZE];

   copy_state_type         state_ff, state_in;
   logic [WINDOW_BITS-1:0] rd_addr_ff, rd_addr_in;
   logic [WINDOW_BITS-1:0] wp_ff, wp_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [RUN_W-1:0]       remain_ff, remain_in;
   logic [EMIT_W-1:0]      emit_cnt_ff, emit_cnt_in;
   logic                   lit_mode_ff, lit_mode_in;
   logic [7:0]             lit_ff, lit_in;
   logic [7:0]             mem_q_ff;
   logic                   rd_ok_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [7:0]             out_byte_ff, out_byte_in;
   logic                   out_last_ff, out_last_in;

   logic [WINDOW_BITS-1:0] rd_offset;
   logic [7:0]             wr_byte;
   logic                   emit, out_free, advance;

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_run_last = out_last_ff;

   // entries outside the written span read as a space
   assign rd_offset = rd_addr_ff - INIT_WP;
   assign wr_byte   = lit_mode_ff ? lit_ff : (rd_ok_ff ? mem_q_ff : SPACE_CHAR);
   assign emit      = (emit_cnt_ff < EMIT_W'(OUT_LIMIT));
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = (state_ff == ST_WRITE) && (!emit || out_free);
   assign cmd_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      rd_addr_in   = rd_addr_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      remain_in    = remain_ff;
      emit_cnt_in  = emit_cnt_ff;
      lit_mode_in  = lit_mode_ff;
      lit_in       = lit_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               emit_cnt_in = '0;
               lit_mode_in = cmd.is_lit;
               lit_in      = cmd.lit;
               rd_addr_in  = cmd.pos;
               if (cmd.is_lit) begin
                  remain_in = '0;
                  state_in  = ST_WRITE;
               end else begin
                  remain_in = RUN_W'(cmd.len) + RUN_W'(MIN_EXTRA);
                  state_in  = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (advance) begin
               wp_in = wp_ff + 1'b1;
               if (fill_ff != FILL_W'(WIN_SIZE)) begin
                  fill_in = fill_ff + 1'b1;
               end
               if (emit) begin
                  out_valid_in = 1'b1;
                  out_byte_in  = wr_byte;
                  out_last_in  = (remain_ff == '0) || (emit_cnt_ff == EMIT_W'(OUT_LIMIT - 1));
                  emit_cnt_in  = emit_cnt_ff + 1'b1;
               end
               if (remain_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  remain_in  = remain_ff - 1'b1;
                  rd_addr_in = rd_addr_ff + 1'b1;
                  state_in   = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= INIT_WP;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      remain_ff   <= remain_in;
      emit_cnt_ff <= emit_cnt_in;
      lit_mode_ff <= lit_mode_in;
      lit_ff      <= lit_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   // window memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (advance) begin
         window[wp_ff] <= wr_byte;
      end
      if (state_ff == ST_READ) begin
         mem_q_ff <= window[rd_addr_ff];
         rd_ok_ff <= ({1'b0, rd_offset} < fill_ff);
      end
   end

endmodule

/* rtl/core/lzss_stream_decoder.sv */
// ----------------------------------------------------------------------------
// lzss_stream_decoder
// LZSS decompressor taking one compressed byte per req word and producing
// one decompressed byte per rsp word.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries the compressed stream, one byte per word, consumed
//   most significant bit first. rsp channel returns decoded bytes; rsp_run_last
//   marks the last byte caused by a given input byte. Input bytes that finish
//   no token produce no rsp word.
//   A literal is queued, popped by the copier in its idle state, written in
//   its write state and placed in the result register; a match byte adds a
//   window read before each write. The parser takes a byte per cycle while
//   the two-entry command queue has room; the copier pops one command at a
//   time, takes no new one until the current one is done, and handles each
//   match byte as a window read, then a write and emit.
//   Reset clears the token register, the queue and the result register; the
//   window needs no clearing pass: a fill count marks the span written since
//   reset and every other entry reads as a space. req_ready is high the cycle
//   after reset.
//   When the receiver stalls, the result register holds; the copier waits,
//   the queue fills, and then req_ready drops.
// ----------------------------------------------------------------------------
module lzss_stream_decoder
   import lsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   lsd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_cmd    (push_cmd)
   );

   lsd_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   lsd_copier u_copier (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (pop_valid),
      .cmd_ready    (pop_ready),
      .cmd          (pop_cmd),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

endmodule

/* rtl/core/lsd_checker.sv */
// ----------------------------------------------------------------------------
// lsd_checker
// Port-level checks for the LZSS stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module lsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_out_byte) && $stable(rsp_run_last))
      else $error("rsp word changed while stalled");

   // reset empties the queue and the result register
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not empty after reset");

   // the first rsp word after reset must pass through parse, queue and copy
   a_min_latency: assert property (@(posedge clock)
      $rose(rsp_valid) |-> !$past(reset, 1) && !$past(reset, 2))
      else $error("rsp word too soon after reset");

   // nothing can come out before any input was taken since reset
   a_no_spurious: assert property (@(posedge clock)
      $rose(rsp_valid) |-> !$past(reset, 3) || $past(req_valid && req_ready, 2))
      else $error("rsp word without input");

endmodule

bind lzss_stream_decoder lsd_checker u_lsd_checker (.*);
